[sv/fswa_pkg.sv]
// Package for the frame statistics window average block.
// Holds widths, defaults, the back-end state enum and the queue entry type.
`default_nettype none
package fswa_pkg;
    localparam int unsigned LUMA_W      = 16;
    localparam int unsigned SLOT_W      = 7;
    localparam int unsigned SUM_W       = 37;
    localparam int unsigned CNT_W       = 21;
    localparam int unsigned HISTORY_SLOTS_DEF     = 128;
    localparam int unsigned WINDOW_LENGTH_DEF     = 32;
    localparam int unsigned MAX_FRAME_SAMPLES_DEF = 65536;
    localparam logic [SLOT_W-1:0] WINDOW_RESET = 7'd33;
    localparam logic [LUMA_W-1:0] LUMA_FULL = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_WRITE, ST_WALK, ST_DRAIN, ST_STORE, ST_OUT
    } t_back_state;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
        logic [LUMA_W-1:0] min;
        logic [LUMA_W-1:0] max;
        logic [SLOT_W-1:0] slot;
    } t_frame_rec;
endpackage
`default_nettype wire

[sv/fswa_if.sv]
// Valid/ready channel interfaces for the frame statistics block.
// Depends on fswa_pkg for field widths.
`default_nettype none
interface fswa_in_if;
    logic                      valid;
    logic                      ready;
    logic [fswa_pkg::LUMA_W-1:0] luma_sample;
    logic                      last_sample;
    logic [fswa_pkg::SLOT_W-1:0] frame_slot;
    modport source (output valid, luma_sample, last_sample, frame_slot, input ready);
    modport sink   (input valid, luma_sample, last_sample, frame_slot, output ready);
endinterface

interface fswa_out_if;
    logic                      valid;
    logic                      ready;
    logic [fswa_pkg::LUMA_W-1:0] frame_mean;
    logic [fswa_pkg::LUMA_W-1:0] frame_min;
    logic [fswa_pkg::LUMA_W-1:0] frame_max;
    logic [fswa_pkg::LUMA_W-1:0] window_mean;
    logic [fswa_pkg::LUMA_W-1:0] window_min;
    logic [fswa_pkg::LUMA_W-1:0] window_max;
    modport source (output valid, frame_mean, frame_min, frame_max, window_mean,
                    window_min, window_max, input ready);
    modport sink   (input valid, frame_mean, frame_min, frame_max, window_mean,
                    window_min, window_max, output ready);
endinterface
`default_nettype wire

[sv/fswa_front.sv]
// Front end: accumulates sum, count, min and max per frame, emits a frame record.
// Depends on fswa_pkg and fswa_in_if.
`default_nettype none
module fswa_front #(
    parameter int unsigned MAX_FRAME_SAMPLES = fswa_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    fswa_in_if.sink                in_ch,
    output fswa_pkg::t_frame_rec   o_rec,
    output logic                   o_rec_valid,
    input  wire logic              i_rec_ready
);
    import fswa_pkg::*;

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LUMA_W-1:0] r_min, n_min, r_max, n_max;
    logic              take;

    // accept only when the queue can take a record
    assign in_ch.ready = i_rec_ready;
    assign take = in_ch.valid && in_ch.ready;

    // fold the sample in unless the frame is full
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_min = r_min;
        n_max = r_max;
        if (r_cnt < CNT_W'(MAX_FRAME_SAMPLES)) begin
            n_sum = r_sum + SUM_W'(in_ch.luma_sample);
            n_cnt = r_cnt + 1'b1;
            if (in_ch.luma_sample > r_max) n_max = in_ch.luma_sample;
            if (in_ch.luma_sample != '0 && in_ch.luma_sample < r_min)
                n_min = in_ch.luma_sample;
        end
    end

    assign o_rec.sum   = n_sum;
    assign o_rec.count = n_cnt;
    assign o_rec.min   = n_min;
    assign o_rec.max   = n_max;
    assign o_rec.slot  = in_ch.frame_slot;
    assign o_rec_valid = take && in_ch.last_sample;

    // advance accumulators, clear at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_min <= LUMA_FULL;
            r_max <= '0;
        end else if (take) begin
            if (in_ch.last_sample) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_min <= LUMA_FULL;
                r_max <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_FRAME_SAMPLES)) else $error("count overflow");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |=> (r_cnt == '0 && r_max == '0)) else $error("no clear");
    a_min_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min != '0) else $error("zero min");
`endif
endmodule
`default_nettype wire

[sv/fswa_queue.sv]
// Two-entry queue of frame records between front and back ends.
// Depends on fswa_pkg.
`default_nettype none
module fswa_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  fswa_pkg::t_frame_rec  i_rec,
    input  wire logic             i_push,
    output logic                  o_not_full,
    output fswa_pkg::t_frame_rec  o_rec,
    output logic                  o_not_empty,
    input  wire logic             i_pop
);
    import fswa_pkg::*;

    t_frame_rec r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_not_full  = r_cnt != 2'd2;
    assign o_not_empty = r_cnt != 2'd0;
    assign o_rec       = r_mem[r_rp];

    // hold records, advance pointers
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_not_full || i_pop)) else $error("queue overflow");
    a_no_udf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
`endif
endmodule
`default_nettype wire

[sv/fswa_back.sv]
// Back end: divides for the mean, updates the history memories, walks the
// window and emits the result. Depends on fswa_pkg and fswa_out_if.
`default_nettype none
module fswa_back #(
    parameter int unsigned HISTORY_SLOTS = fswa_pkg::HISTORY_SLOTS_DEF,
    parameter int unsigned WINDOW_LENGTH = fswa_pkg::WINDOW_LENGTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [fswa_pkg::SLOT_W-1:0] i_win_first,
    input  fswa_pkg::t_frame_rec             i_rec,
    input  wire logic                        i_rec_valid,
    output logic                             o_pop,
    fswa_out_if.source                       out_ch
);
    import fswa_pkg::*;

    localparam int unsigned AW  = $clog2(HISTORY_SLOTS);
    localparam int unsigned WW  = $clog2(WINDOW_LENGTH + 1);
    localparam int unsigned ACW = LUMA_W + WW;
    localparam int unsigned QW  = LUMA_W + 1;

    t_back_state r_st, n_st;

    // history memories, cleared by a sweep after reset
    logic [LUMA_W-1:0] r_mean_mem [HISTORY_SLOTS];
    logic [LUMA_W-1:0] r_min_mem  [HISTORY_SLOTS];
    logic [LUMA_W-1:0] r_max_mem  [HISTORY_SLOTS];
    logic [LUMA_W-1:0] r_rd_mean, r_rd_min, r_rd_max;

    logic [AW:0]       r_clr;
    logic              clearing;
    logic [SUM_W-1:0]  r_rem;
    logic [QW-1:0]     r_quo;
    logic [CNT_W-1:0]  r_div;
    logic [5:0]        r_bit;
    logic [LUMA_W-1:0] r_mean, r_min, r_max;
    logic [AW-1:0]     r_slot, r_addr;
    logic [WW-1:0]     r_k;
    logic              r_rdv;
    logic [ACW-1:0]    r_acc_mean, r_acc_min, r_acc_max;
    logic [LUMA_W-1:0] r_w_mean, r_w_min, r_w_max;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [LUMA_W-1:0] wd_mean, wd_min, wd_max;
    logic [SUM_W-1:0]  trial;
    logic [AW-1:0]     first_addr;

    // fold a 7-bit slot into the table; one subtract covers any depth of 64 or more
    function automatic logic [AW-1:0] wrap_slot(input logic [SLOT_W-1:0] s);
        if (32'(s) >= HISTORY_SLOTS) return AW'(32'(s) - HISTORY_SLOTS);
        return AW'(s);
    endfunction

    assign clearing   = !r_clr[AW];
    assign first_addr = wrap_slot(i_win_first);
    assign trial      = {r_rem[SUM_W-2:0], 1'b0};

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (i_rec_valid && !clearing) n_st = ST_DIV;
            ST_DIV:   if (r_bit == 6'd0) n_st = ST_WRITE;
            ST_WRITE: n_st = ST_WALK;
            ST_WALK:  if (r_k == WW'(WINDOW_LENGTH - 1)) n_st = ST_DRAIN;
            ST_DRAIN: n_st = ST_STORE;
            ST_STORE: n_st = ST_OUT;
            ST_OUT:   if (out_ch.ready) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop   = 1'b0;
        we      = 1'b0;
        waddr   = r_slot;
        wd_mean = r_mean;
        wd_min  = r_min;
        wd_max  = r_max;
        case (r_st)
            ST_IDLE:  o_pop = i_rec_valid && !clearing;
            ST_WRITE: begin
                we = 1'b1;
                wd_mean = r_quo[LUMA_W-1:0];
            end
            ST_STORE: begin
                we = 1'b1;
                waddr = '0;
                wd_mean = r_w_mean;
                wd_min = r_w_min;
                wd_max = r_w_max;
            end
            default:  we = 1'b0;
        endcase
        if (clearing) begin
            we = 1'b1;
            waddr = r_clr[AW-1:0];
            wd_mean = '0;
            wd_min = '0;
            wd_max = '0;
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mean_mem[waddr] <= wd_mean;
            r_min_mem[waddr]  <= wd_min;
            r_max_mem[waddr]  <= wd_max;
        end
        r_rd_mean <= r_mean_mem[r_addr];
        r_rd_min  <= r_min_mem[r_addr];
        r_rd_max  <= r_max_mem[r_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_clr <= '0;
            r_rdv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (clearing) r_clr <= r_clr + 1'b1;
            r_rdv <= (r_st == ST_WALK);
        end
    end

    // datapath: restoring divide, window walk, accumulate
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_rem  <= i_rec.sum;
                r_div  <= i_rec.count;
                r_quo  <= '0;
                r_bit  <= 6'(QW - 1);
                r_min  <= i_rec.min;
                r_max  <= i_rec.max;
                r_slot <= wrap_slot(i_rec.slot);
            end
            ST_DIV: begin
                if (r_div == '0) begin
                    r_quo <= '0;
                end else if ((r_rem >> r_bit) >= SUM_W'(r_div)) begin
                    r_rem <= r_rem - (SUM_W'(r_div) << r_bit);
                    r_quo[r_bit[$clog2(QW)-1:0]] <= 1'b1;
                end
                r_bit <= r_bit - 1'b1;
            end
            ST_WRITE: begin
                r_mean     <= r_quo[LUMA_W-1:0];
                r_addr     <= first_addr;
                r_k        <= '0;
                r_acc_mean <= '0;
                r_acc_min  <= '0;
                r_acc_max  <= '0;
            end
            ST_WALK: begin
                r_addr <= (r_addr == AW'(HISTORY_SLOTS - 1)) ? '0 : r_addr + 1'b1;
                r_k    <= r_k + 1'b1;
            end
            default: ;
        endcase
        if (r_rdv) begin
            r_acc_mean <= r_acc_mean + ACW'(r_rd_mean);
            r_acc_min  <= r_acc_min + ACW'(r_rd_min);
            r_acc_max  <= r_acc_max + ACW'(r_rd_max);
        end
        // fold in the last window entry while averaging
        if (r_st == ST_DRAIN) begin
            r_w_mean <= LUMA_W'((r_acc_mean + ACW'(r_rd_mean)) / WINDOW_LENGTH);
            r_w_min  <= LUMA_W'((r_acc_min + ACW'(r_rd_min)) / WINDOW_LENGTH);
            r_w_max  <= LUMA_W'((r_acc_max + ACW'(r_rd_max)) / WINDOW_LENGTH);
        end
    end

    assign out_ch.valid       = (r_st == ST_OUT);
    assign out_ch.frame_mean  = r_mean;
    assign out_ch.frame_min   = r_min;
    assign out_ch.frame_max   = r_max;
    assign out_ch.window_mean = r_w_mean;
    assign out_ch.window_min  = r_w_min;
    assign out_ch.window_max  = r_w_max;

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == ST_DIV)) else $error("pop without start");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result lost");
    a_no_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (r_st == ST_IDLE)) else $error("work during clear");
`endif
endmodule
`default_nettype wire

[sv/frame_stats_window_average_unit.sv]
// Frame statistics with window average: top level.
// Depends on fswa_pkg, fswa_if, fswa_front, fswa_queue, fswa_back.
//
// Usage:
//   in_ch carries one luma sample per transfer with a last flag and a slot.
//   Samples are taken one per cycle while the queue is not full.
//   On the last sample a frame record enters a two-entry queue; the back
//   end divides sum by count (one quotient bit per cycle), writes the
//   history memories, walks the window (WINDOW_LENGTH reads on one port,
//   then a drain step to finish the sums), stores the averages in slot 0
//   and presents the result on out_ch.
//   Samples of the next frame stream on meanwhile; the input stalls only
//   when two finished frames wait in the queue.
//   The result is held until out_ch.ready; a stall backs up the queue.
//   i_cfg_we writes window_first_slot; the user must do so only while the
//   block is idle, as the block itself does not enforce it. Reset (i_rst_n
//   low, synchronous) clears accumulators and starts a sweep that zeroes
//   the history; frame ends wait for it to finish.
`default_nettype none
module frame_stats_window_average_unit #(
    parameter int unsigned HISTORY_SLOTS     = fswa_pkg::HISTORY_SLOTS_DEF,
    parameter int unsigned WINDOW_LENGTH     = fswa_pkg::WINDOW_LENGTH_DEF,
    parameter int unsigned MAX_FRAME_SAMPLES = fswa_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [fswa_pkg::SLOT_W-1:0] i_cfg_data,
    fswa_in_if.sink                          in_ch,
    fswa_out_if.source                       out_ch
);
    import fswa_pkg::*;

    logic [SLOT_W-1:0] r_win_first;
    t_frame_rec        front_rec, q_rec;
    logic              push, not_full, not_empty, pop;

    // hold the window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_win_first <= WINDOW_RESET;
        else if (i_cfg_we) r_win_first <= i_cfg_data;
    end

    fswa_front #(.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)) u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_rec(front_rec), .o_rec_valid(push), .i_rec_ready(not_full)
    );

    fswa_queue u_queue (
        .i_clk, .i_rst_n, .i_rec(front_rec), .i_push(push), .o_not_full(not_full),
        .o_rec(q_rec), .o_not_empty(not_empty), .i_pop(pop)
    );

    fswa_back #(.HISTORY_SLOTS(HISTORY_SLOTS), .WINDOW_LENGTH(WINDOW_LENGTH)) u_back (
        .i_clk, .i_rst_n, .i_win_first(r_win_first), .i_rec(q_rec),
        .i_rec_valid(not_empty), .o_pop(pop), .out_ch
    );
endmodule
`default_nettype wire
